@@ sv/dcs_pkg.sv @@
// Shared types and codes for the disc drive command sequencer.
// No dependencies; imported by every module of the block.
package dcs_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int NUM_COUNTERS      = 7;

  localparam int CMD_W    = 3;
  localparam int SECTOR_W = 19;
  localparam int BYTE_W   = 8;
  localparam int DC_W     = 4;
  localparam int RA_W     = 2;
  localparam int ST_W     = 4;
  localparam int FK_W     = 3;
  localparam int CNT_OUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SEL_W    = 3;

  // input commands
  localparam logic [CMD_W-1:0] CMD_EVENT      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START_READ = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START_SEEK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START_PAUSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_MODE   = 3'd4;

  // sequencer states
  localparam logic [ST_W-1:0] ST_IDLE         = 4'd0;
  localparam logic [ST_W-1:0] ST_READ_SETLOC  = 4'd1;
  localparam logic [ST_W-1:0] ST_READ_RUN     = 4'd2;
  localparam logic [ST_W-1:0] ST_SEEK_SETLOC  = 4'd3;
  localparam logic [ST_W-1:0] ST_SEEK_RUN     = 4'd4;
  localparam logic [ST_W-1:0] ST_DONE         = 4'd5;
  localparam logic [ST_W-1:0] ST_READ_RETRY   = 4'd6;
  localparam logic [ST_W-1:0] ST_HALT         = 4'd7;
  localparam logic [ST_W-1:0] ST_ADPCM_MODE   = 4'd8;
  localparam logic [ST_W-1:0] ST_ADPCM_FILTER = 4'd9;
  localparam logic [ST_W-1:0] ST_SET_MODE     = 4'd10;
  localparam logic [ST_W-1:0] ST_ERR_WAIT     = 4'd11;
  localparam logic [ST_W-1:0] ST_ERR_HANDLE   = 4'd12;

  // fault kinds
  localparam logic [FK_W-1:0] FK_NONE    = 3'd0;
  localparam logic [FK_W-1:0] FK_SEEK    = 3'd1;
  localparam logic [FK_W-1:0] FK_GENERIC = 3'd2;
  localparam logic [FK_W-1:0] FK_READ    = 3'd3;
  localparam logic [FK_W-1:0] FK_HALT    = 3'd4;
  localparam logic [FK_W-1:0] FK_ADPCM   = 3'd5;
  localparam logic [FK_W-1:0] FK_MODE    = 3'd6;

  // drive commands
  localparam logic [DC_W-1:0] DC_NONE      = 4'd0;
  localparam logic [DC_W-1:0] DC_NOP       = 4'd1;
  localparam logic [DC_W-1:0] DC_SETLOC    = 4'd2;
  localparam logic [DC_W-1:0] DC_READN     = 4'd3;
  localparam logic [DC_W-1:0] DC_SEEKL     = 4'd4;
  localparam logic [DC_W-1:0] DC_PAUSE     = 4'd5;
  localparam logic [DC_W-1:0] DC_STOP      = 4'd6;
  localparam logic [DC_W-1:0] DC_SETFILTER = 4'd7;
  localparam logic [DC_W-1:0] DC_SETMODE   = 4'd8;
  localparam logic [DC_W-1:0] DC_GETTN     = 4'd9;

  // ready handler actions
  localparam logic [RA_W-1:0] RA_NONE    = 2'd0;
  localparam logic [RA_W-1:0] RA_ARM     = 2'd1;
  localparam logic [RA_W-1:0] RA_DISARM  = 2'd2;
  localparam logic [RA_W-1:0] RA_RESTORE = 2'd3;

  // statistics counter slots
  localparam int CNT_SETLOC_READ    = 0;
  localparam int CNT_READ_OK        = 1;
  localparam int CNT_READ_FAIL      = 2;
  localparam int CNT_RETRY          = 3;
  localparam int CNT_RETRY_FAIL     = 4;
  localparam int CNT_HALT_OK        = 5;
  localparam int CNT_HALT_MODE_FAIL = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_SELECT = 2'd1;

  typedef logic [NUM_COUNTERS-1:0] dcs_bump_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic                status_ok;
    logic                shell_open;
    logic [SECTOR_W-1:0] target_sector;
    logic [BYTE_W-1:0]   mode_value;
  } dcs_item_t;

  typedef struct packed {
    logic [DC_W-1:0]     drive_command;
    logic [SECTOR_W-1:0] param_sector;
    logic [BYTE_W-1:0]   param_first;
    logic [BYTE_W-1:0]   param_second;
    logic [RA_W-1:0]     ready_action;
    logic [ST_W-1:0]     seq_state;
    logic [FK_W-1:0]     fault_kind;
    logic                is_idle;
  } dcs_result_t;

endpackage

@@ sv/dcs_ctrl.sv @@
// Sequencer state registers and the per-transfer decision logic.
// Depends on dcs_pkg.
module dcs_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  dcs_pkg::dcs_item_t                item,
  input  logic [dcs_pkg::BYTE_W-1:0]        filter_channel,
  output dcs_pkg::dcs_result_t              res,
  output dcs_pkg::dcs_bump_t                bump
);
  import dcs_pkg::*;

  logic [ST_W-1:0]     st_r, st_nxt;
  logic [FK_W-1:0]     fk_r, fk_nxt;
  logic [SECTOR_W-1:0] loc_r, loc_nxt;
  logic [BYTE_W-1:0]   mode_r, mode_nxt;
  logic [DC_W-1:0]     dc;
  logic [RA_W-1:0]     ra;

  always_comb begin
    st_nxt   = st_r;
    fk_nxt   = fk_r;
    loc_nxt  = loc_r;
    mode_nxt = mode_r;
    dc       = DC_NONE;
    ra       = RA_NONE;
    bump     = '0;
    case (item.command)
      CMD_START_READ: begin
        loc_nxt = item.target_sector;
        st_nxt  = ST_READ_SETLOC;
        bump[CNT_SETLOC_READ] = 1'b1;
        ra = RA_ARM;
        dc = DC_SETLOC;
      end
      CMD_START_SEEK: begin
        loc_nxt = item.target_sector;
        st_nxt  = ST_SEEK_SETLOC;
        dc      = DC_SETLOC;
      end
      CMD_START_PAUSE: begin
        st_nxt = ST_DONE;
        dc     = DC_PAUSE;
      end
      CMD_SET_MODE: begin
        mode_nxt = item.mode_value;
        st_nxt   = ST_SET_MODE;
        dc       = DC_SETMODE;
      end
      CMD_EVENT: begin
        case (st_r)
          ST_READ_SETLOC, ST_READ_RUN: begin
            if (item.status_ok) begin
              bump[CNT_READ_OK] = 1'b1;
              if (st_r == ST_READ_SETLOC) begin
                st_nxt = ST_READ_RUN;
                dc     = DC_READN;
              end else begin
                st_nxt = ST_IDLE;
              end
            end else begin
              bump[CNT_READ_FAIL] = 1'b1;
              ra     = RA_DISARM;
              fk_nxt = FK_READ;
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end
          end
          ST_SEEK_SETLOC: begin
            if (item.status_ok) begin
              st_nxt = ST_SEEK_RUN;
              dc     = DC_SEEKL;
            end else begin
              fk_nxt = FK_SEEK;
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end
          end
          ST_SEEK_RUN: begin
            if (item.status_ok) begin
              st_nxt = ST_IDLE;
            end else begin
              fk_nxt = FK_SEEK;
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end
          end
          ST_DONE: begin
            if (item.status_ok) begin
              st_nxt = ST_IDLE;
            end else begin
              fk_nxt = FK_GENERIC;
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end
          end
          ST_READ_RETRY, ST_ADPCM_FILTER: begin
            if (item.status_ok) begin
              st_nxt = ST_READ_SETLOC;
              bump[CNT_SETLOC_READ] = 1'b1;
              bump[CNT_RETRY]       = 1'b1;
              ra = RA_RESTORE;
              dc = DC_SETLOC;
            end else begin
              bump[CNT_RETRY_FAIL] = 1'b1;
              fk_nxt = (st_r == ST_READ_RETRY) ? FK_READ : FK_ADPCM;
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end
          end
          ST_HALT: begin
            if (item.status_ok) begin
              st_nxt = ST_READ_RETRY;
              bump[CNT_HALT_OK] = 1'b1;
              dc = DC_PAUSE;
            end else begin
              bump[CNT_HALT_MODE_FAIL] = 1'b1;
              fk_nxt = FK_HALT;
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end
          end
          ST_ADPCM_MODE: begin
            if (item.status_ok) begin
              st_nxt = ST_ADPCM_FILTER;
              dc     = DC_SETFILTER;
            end else begin
              fk_nxt = FK_ADPCM;
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end
          end
          ST_SET_MODE: begin
            if (item.status_ok) begin
              st_nxt = ST_DONE;
              dc     = DC_PAUSE;
            end else begin
              bump[CNT_HALT_MODE_FAIL] = 1'b1;
              fk_nxt = FK_MODE;
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end
          end
          ST_ERR_WAIT: begin
            // wait for a good report with the lid shut
            if (item.status_ok && !item.shell_open) begin
              st_nxt = ST_ERR_HANDLE;
              dc     = DC_GETTN;
            end else begin
              dc = DC_NOP;
            end
          end
          ST_ERR_HANDLE: begin
            if (!item.status_ok) begin
              st_nxt = ST_ERR_WAIT;
              dc     = DC_NOP;
            end else begin
              case (fk_r)
                FK_SEEK: begin
                  st_nxt = ST_SEEK_SETLOC;
                  dc     = DC_SETLOC;
                end
                FK_GENERIC: begin
                  st_nxt = ST_DONE;
                  dc     = DC_PAUSE;
                end
                FK_READ: begin
                  st_nxt = ST_READ_RETRY;
                  dc     = DC_PAUSE;
                end
                FK_HALT: begin
                  st_nxt = ST_HALT;
                  dc     = DC_STOP;
                end
                FK_ADPCM: begin
                  st_nxt = ST_ADPCM_MODE;
                  dc     = DC_SETMODE;
                end
                FK_MODE: begin
                  st_nxt = ST_SET_MODE;
                  dc     = DC_SETMODE;
                end
                default: begin
                  // no fault recorded: nothing to retry
                end
              endcase
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        // unused command codes are ignored
      end
    endcase
  end

  always_comb begin
    res.drive_command = dc;
    res.param_sector  = (dc == DC_SETLOC) ? loc_nxt : '0;
    if (dc == DC_SETMODE) begin
      res.param_first = mode_nxt;
    end else if (dc == DC_SETFILTER) begin
      res.param_first = BYTE_W'(1);
    end else begin
      res.param_first = '0;
    end
    res.param_second = (dc == DC_SETFILTER) ? filter_channel : '0;
    res.ready_action = ra;
    res.seq_state    = st_nxt;
    res.fault_kind   = fk_nxt;
    res.is_idle      = (st_nxt == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      fk_r   <= FK_NONE;
      loc_r  <= '0;
      mode_r <= '0;
    end else if (go) begin
      st_r   <= st_nxt;
      fk_r   <= fk_nxt;
      loc_r  <= loc_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

@@ sv/dcs_stats.sv @@
// Bank of wrapping statistics counters with a selected read-out.
// Depends on dcs_pkg.
module dcs_stats #(
  parameter int COUNTER_WIDTH = dcs_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  dcs_pkg::dcs_bump_t             bump,
  input  logic [dcs_pkg::SEL_W-1:0]      sel,
  output logic [dcs_pkg::CNT_OUT_W-1:0]  value
);
  import dcs_pkg::*;

  logic [COUNTER_WIDTH-1:0] cnt_r   [NUM_COUNTERS];
  logic [COUNTER_WIDTH-1:0] cnt_nxt [NUM_COUNTERS];
  logic [31:0]              sel_ext;

  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      cnt_nxt[i] = cnt_r[i] + COUNTER_WIDTH'(bump[i]);
    end
  end

  // read-out shows the value after this transfer
  always_comb begin
    if (sel < SEL_W'(NUM_COUNTERS)) begin
      sel_ext = 32'(cnt_nxt[sel]);
    end else begin
      sel_ext = '0;
    end
    value = sel_ext[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (go) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

@@ sv/disc_drive_command_sequencer_unit.sv @@
// Takes one item per cycle into an input register unless in_stall is high; the sequencer
// step and the counter update run on the registered item and land in the result register.
// The input stalls only when both the input register and the result register are full
// and the result side is stalling. Configuration is written through cfg_write_en.
// Depends on dcs_pkg, dcs_ctrl and dcs_stats.
module disc_drive_command_sequencer_unit #(
  parameter int COUNTER_WIDTH = dcs_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dcs_pkg::CMD_W-1:0]          in_command,
  input  logic                               in_status_ok,
  input  logic                               in_shell_open,
  input  logic [dcs_pkg::SECTOR_W-1:0]       in_target_sector,
  input  logic [dcs_pkg::BYTE_W-1:0]         in_mode_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dcs_pkg::DC_W-1:0]           out_drive_command,
  output logic [dcs_pkg::SECTOR_W-1:0]       out_param_sector,
  output logic [dcs_pkg::BYTE_W-1:0]         out_param_first,
  output logic [dcs_pkg::BYTE_W-1:0]         out_param_second,
  output logic [dcs_pkg::RA_W-1:0]           out_ready_action,
  output logic [dcs_pkg::ST_W-1:0]           out_seq_state,
  output logic [dcs_pkg::FK_W-1:0]           out_fault_kind,
  output logic                               out_is_idle,
  output logic [dcs_pkg::CNT_OUT_W-1:0]      out_counter_value,
  input  logic                               cfg_write_en,
  input  logic [dcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcs_pkg::BYTE_W-1:0]         cfg_data
);
  import dcs_pkg::*;

  logic                   s1_valid_r, s1_valid_nxt;
  dcs_item_t              s1_item_r;
  logic                   out_valid_r, out_valid_nxt;
  dcs_result_t            out_res_r;
  logic [CNT_OUT_W-1:0]   out_cnt_r;
  logic [BYTE_W-1:0]      filter_channel_r;
  logic [SEL_W-1:0]       counter_select_r;

  logic                   in_xfer;
  logic                   adv;
  dcs_item_t              in_item;
  dcs_result_t            step_res;
  dcs_bump_t              step_bump;
  logic [CNT_OUT_W-1:0]   step_cnt;

  assign in_item.command       = in_command;
  assign in_item.status_ok     = in_status_ok;
  assign in_item.shell_open    = in_shell_open;
  assign in_item.target_sector = in_target_sector;
  assign in_item.mode_value    = in_mode_value;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  dcs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (adv),
    .item           (s1_item_r),
    .filter_channel (filter_channel_r),
    .res            (step_res),
    .bump           (step_bump)
  );

  dcs_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (adv),
    .bump  (step_bump),
    .sel   (counter_select_r),
    .value (step_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      filter_channel_r <= '0;
      counter_select_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_FILTER_CHANNEL: filter_channel_r <= cfg_data;
          CFG_COUNTER_SELECT: counter_select_r <= cfg_data[SEL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_res_r <= step_res;
      out_cnt_r <= step_cnt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_command = out_res_r.drive_command;
  assign out_param_sector  = out_res_r.param_sector;
  assign out_param_first   = out_res_r.param_first;
  assign out_param_second  = out_res_r.param_second;
  assign out_ready_action  = out_res_r.ready_action;
  assign out_seq_state     = out_res_r.seq_state;
  assign out_fault_kind    = out_res_r.fault_kind;
  assign out_is_idle       = out_res_r.is_idle;
  assign out_counter_value = out_cnt_r;

`ifndef NO_ASSERTIONS
  // input only stalls behind a full input register
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // an accepted transfer is held until it moves on
  a_xfer_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted transfer lost");

  // a retry always reissues setloc together with the read count
  a_retry_setloc: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && step_bump[CNT_RETRY]) |-> (step_bump[CNT_SETLOC_READ] &&
      step_res.drive_command == DC_SETLOC && step_res.ready_action == RA_RESTORE))
    else $error("retry without setloc");

  // channel byte goes out only with set-filter
  a_filter_param: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.drive_command == DC_SETFILTER ||
      out_res_r.param_second == '0))
    else $error("stray filter channel");

  // idle flag tracks the reported state
  a_idle_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.is_idle == (out_res_r.seq_state == ST_IDLE)))
    else $error("idle flag mismatch");
`endif

endmodule
